// ----- src/spqm_pkg.sv -----
package spqm_pkg;

    localparam int unsigned FRAMES_TO_TRUST = 8;

    localparam logic [15:0] PULSE_MIN   = 16'd800;
    localparam logic [15:0] PULSE_MAX   = 16'd2200;
    localparam logic [11:0] LOW_CAL_LIM = 12'd1250;
    localparam logic [11:0] HIGH_DRIFT  = 12'd50;
    localparam logic [7:0]  HIGH_COUNT  = 8'd50;
    localparam logic [6:0]  LOW_COUNT   = 7'd75;
    localparam logic [11:0] CAL_OFFSET  = 12'd25;
    localparam logic [11:0] HIGH_BASE   = 12'd1750;
    localparam logic [11:0] LOW_BASE    = 12'd750;
    localparam logic [10:0] UNI_OUT_LO  = 11'd47;
    localparam logic [10:0] UNI_SPAN    = 11'd2000;
    localparam logic [10:0] UNI_ZERO    = 11'd48;
    localparam logic [10:0] BI_UP_LO    = 11'd1001;
    localparam logic [10:0] BI_UP_SPAN  = 11'd999;
    localparam logic [10:0] BI_DN_SPAN  = 11'd1000;

    localparam int unsigned QUOT_W = 11;
    localparam int unsigned PROD_W = 23;

    // register indexes on the configuration port
    localparam logic [2:0] REG_BIDIR     = 3'd0;
    localparam logic [2:0] REG_INIT_LOW  = 3'd1;
    localparam logic [2:0] REG_INIT_HIGH = 3'd2;
    localparam logic [2:0] REG_NEUTRAL   = 3'd3;
    localparam logic [2:0] REG_MAX_STEP  = 3'd4;
    localparam logic [2:0] REG_MAX_JIT   = 3'd5;

    localparam logic [10:0] RST_INIT_LOW  = 11'd1000;
    localparam logic [11:0] RST_INIT_HIGH = 12'd2000;
    localparam logic [10:0] RST_NEUTRAL   = 11'd1500;
    localparam logic [10:0] RST_MAX_STEP  = 11'd250;
    localparam logic [10:0] RST_MAX_JIT   = 11'd400;

    typedef struct packed {
        logic        bidir;
        logic [10:0] init_low;
        logic [11:0] init_high;
        logic [10:0] neutral;
        logic [10:0] max_step;
        logic [10:0] max_jitter;
        logic        ld_low;
        logic        ld_high;
    } t_cfg;

    typedef struct packed {
        logic capture;
        logic eval;
        logic mul;
        logic div_step;
        logic finish;
    } t_ctl_cmd;

    typedef struct packed {
        logic map_req;
        logic out_hold;
    } t_ctl_stat;

    // (thr - base) / 2 truncated toward zero, saturated to ten bits
    function automatic logic [9:0] code_of(input logic [11:0] thr, input logic [11:0] base);
        logic signed [12:0] diff;
        logic signed [12:0] half;
        logic [9:0]         res;
        diff = $signed({1'b0, thr}) - $signed({1'b0, base});
        half = (diff + $signed({12'd0, diff[12]})) >>> 1;
        if (half > 13'sd511) begin
            res = 10'h1FF;
        end else if (half < -13'sd512) begin
            res = 10'h200;
        end else begin
            res = half[9:0];
        end
        return res;
    endfunction

endpackage

// ----- src/spqm_ctrl.sv -----
module spqm_ctrl
    import spqm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_ctl_stat i_stat,
    output t_ctl_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EVAL = 5'b00010,
        S_MUL  = 5'b00100,
        S_DIV  = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    t_state     r_state, n_state;
    logic [3:0] r_cnt, n_cnt;

    // sequencing of one item
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state = i_stat.map_req ? S_MUL : S_FIN;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_cnt = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'(QUOT_W - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!i_stat.out_hold) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ----- src/spqm_dpath.sv -----
module spqm_dpath
    import spqm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  t_ctl_cmd    i_cmd,
    output t_ctl_stat   o_stat,
    input  logic        i_cmd_bit,
    input  logic [15:0] i_pulse,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [39:0] o_data
);

    // captured item
    logic        r_cmd;
    logic [15:0] r_pulse;

    // block state
    logic [11:0] r_prev, n_prev;
    logic [3:0]  r_steady, n_steady;
    logic [10:0] r_raw;
    logic [10:0] r_out_thr;
    logic        r_cal, n_cal;
    logic        r_hset, n_hset;
    logic [7:0]  r_hsamp, n_hsamp;
    logic [6:0]  r_lsamp, n_lsamp;
    logic [11:0] r_lref, n_lref;
    logic [11:0] r_hthr, n_hthr;
    logic [11:0] r_lthr, n_lthr;

    // per-item flags
    logic r_seen, n_seen, r_clr, n_clr, r_saved, n_saved, r_slew, n_slew, r_map, n_map;

    // mapping operands and divider
    logic [11:0]       n_diff, r_diff;
    logic [10:0]       n_span, r_span;
    logic [11:0]       n_dvs, r_dvs;
    logic [10:0]       n_olo, r_olo;
    logic              n_degen, r_degen;
    logic              r_uni;
    logic [PROD_W-1:0] r_acc;

    // output register
    logic        r_ovalid;
    logic [36:0] r_odata;

    wire [11:0] p12 = r_pulse[11:0];

    // qualification and calibration of one pulse
    always_comb begin
        logic        in_rng;
        logic [11:0] jit;
        logic [11:0] lhr;
        logic [11:0] d;
        logic [14:0] avg;
        logic [11:0] lo, hi, x;
        n_prev = r_prev; n_steady = r_steady; n_cal = r_cal; n_hset = r_hset;
        n_hsamp = r_hsamp; n_lsamp = r_lsamp; n_lref = r_lref;
        n_hthr = r_hthr; n_lthr = r_lthr;
        n_seen = 1'b0; n_clr = 1'b0; n_saved = 1'b0; n_slew = 1'b1; n_map = 1'b0;
        in_rng = 1'b0; jit = '0; lhr = '0; d = '0; avg = '0;
        if (r_cmd) begin
            if (!r_hset) begin
                n_cal = 1'b1;
            end
            n_slew = 1'b0;
        end else begin
            in_rng = (r_pulse > PULSE_MIN) && (r_pulse < PULSE_MAX);
            if (in_rng) begin
                jit = (p12 > r_prev) ? p12 - r_prev : r_prev - p12;
                n_prev = p12;
                if (jit > {1'b0, i_cfg.max_jitter}) begin
                    n_steady = '0;
                end else if (r_steady < 4'(FRAMES_TO_TRUST)) begin
                    n_steady = r_steady + 4'd1;
                end
                if (n_steady < 4'(FRAMES_TO_TRUST)) begin
                    n_clr  = 1'b1;
                    n_slew = 1'b0;
                end else begin
                    n_seen = 1'b1;
                end
            end else begin
                n_steady = '0;
                n_clr    = 1'b1;
            end
            if (n_seen) begin
                if (r_cal) begin
                    if (!r_hset) begin
                        lhr = (r_hsamp == '0) ? p12 : r_lref;
                        n_hsamp = r_hsamp + 8'd1;
                        d = (lhr > r_hthr) ? lhr - r_hthr : r_hthr - lhr;
                        if (d > HIGH_DRIFT) begin
                            n_cal = 1'b0;
                        end else begin
                            avg = 15'd7 * {3'd0, r_hthr} + {3'd0, p12};
                            n_hthr = avg[14:3];
                            if (n_hsamp > HIGH_COUNT) begin
                                n_hthr = n_hthr - CAL_OFFSET;
                                n_hset = 1'b1;
                            end
                        end
                        n_lref = n_hthr;
                    end
                    if (n_hset) begin
                        if (p12 < LOW_CAL_LIM) begin
                            n_lsamp = r_lsamp + 7'd1;
                            avg = 15'd7 * {3'd0, r_lthr} + {3'd0, p12};
                            n_lthr = avg[14:3];
                        end
                        if (n_lsamp > LOW_COUNT) begin
                            n_lthr  = n_lthr + CAL_OFFSET;
                            n_cal   = 1'b0;
                            n_lsamp = '0;
                            n_saved = 1'b1;
                        end
                    end
                end else begin
                    n_map = 1'b1;
                end
            end
        end
        // mapping bounds from the current thresholds
        if (i_cfg.bidir) begin
            if (p12 <= {1'b0, i_cfg.neutral}) begin
                lo = r_lthr; hi = {1'b0, i_cfg.neutral};
                n_olo = '0; n_span = BI_DN_SPAN;
            end else begin
                lo = {1'b0, i_cfg.neutral} + 12'd1; hi = r_hthr;
                n_olo = BI_UP_LO; n_span = BI_UP_SPAN;
            end
        end else begin
            lo = r_lthr; hi = r_hthr;
            n_olo = UNI_OUT_LO; n_span = UNI_SPAN;
        end
        n_degen = (hi <= lo);
        x = p12;
        if (x < lo) x = lo;
        if (x > hi) x = hi;
        n_diff = x - lo;
        n_dvs  = hi - lo;
    end

    assign o_stat.map_req  = n_map;
    assign o_stat.out_hold = r_ovalid && !i_ready;

    // restoring divide step
    logic [12:0] div_t;
    logic [12:0] div_r;
    logic        div_b;
    always_comb begin
        div_t = r_acc[PROD_W-1:QUOT_W-1];
        div_b = (div_t >= {1'b0, r_dvs});
        div_r = div_b ? div_t - {1'b0, r_dvs} : div_t;
    end

    // raw throttle and slew toward it
    logic [10:0] map_raw, raw_use, slew_out;
    always_comb begin
        logic signed [12:0] dr;
        logic signed [12:0] st;
        map_raw = r_degen ? r_olo : r_acc[QUOT_W-1:0] + r_olo;
        if (r_uni && map_raw <= UNI_ZERO) map_raw = '0;
        raw_use = r_map ? map_raw : r_raw;
        dr = $signed({2'b00, raw_use}) - $signed({2'b00, r_out_thr});
        st = $signed({2'b00, i_cfg.max_step});
        if (dr > st) begin
            slew_out = r_out_thr + i_cfg.max_step;
        end else if (-dr > st) begin
            slew_out = r_out_thr - i_cfg.max_step;
        end else begin
            slew_out = raw_use;
        end
        if (!r_slew) slew_out = r_out_thr;
    end

    // payload and operand registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd   <= i_cmd_bit;
            r_pulse <= i_pulse;
        end
        if (i_cmd.eval) begin
            r_seen <= n_seen; r_clr <= n_clr; r_saved <= n_saved;
            r_slew <= n_slew; r_map <= n_map;
            r_diff <= n_diff; r_span <= n_span; r_dvs <= n_dvs;
            r_olo <= n_olo; r_degen <= n_degen; r_uni <= !i_cfg.bidir;
        end
        if (i_cmd.mul) begin
            r_acc <= {11'd0, r_diff} * {12'd0, r_span};
        end else if (i_cmd.div_step) begin
            r_acc <= {div_r[11:0], r_acc[QUOT_W-2:0], div_b};
        end
        if (i_cmd.finish) begin
            r_odata <= {code_of(r_lthr, LOW_BASE), code_of(r_hthr, HIGH_BASE), r_saved,
                        r_hset, r_cal, r_clr, r_seen,
                        (r_steady >= 4'(FRAMES_TO_TRUST)), slew_out};
        end
    end

    // block state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0; r_steady <= '0; r_raw <= '0; r_out_thr <= '0;
            r_cal <= 1'b0; r_hset <= 1'b0; r_hsamp <= '0; r_lsamp <= '0;
            r_lref <= '0; r_hthr <= RST_INIT_HIGH; r_lthr <= {1'b0, RST_INIT_LOW};
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.eval) begin
                r_prev <= n_prev; r_steady <= n_steady; r_cal <= n_cal;
                r_hset <= n_hset; r_hsamp <= n_hsamp; r_lsamp <= n_lsamp;
                r_lref <= n_lref; r_hthr <= n_hthr; r_lthr <= n_lthr;
            end else begin
                if (i_cfg.ld_low)  r_lthr <= {1'b0, i_cfg.init_low};
                if (i_cfg.ld_high) r_hthr <= i_cfg.init_high;
            end
            if (i_cmd.finish) begin
                if (r_map) r_raw <= map_raw;
                r_out_thr <= slew_out;
                r_ovalid  <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = {3'b000, r_odata};

endmodule

// ----- src/servo_pulse_qualifier_mapper.sv -----
// channel   | dir | handshake            | payload
// s stream  | in  | i_s_tvalid/o_s_tready | tuser: cmd; tdata: pulse_width
// m stream  | out | o_m_tvalid/i_m_tready | tdata: throttle, flags, codes
// apb       | in  | psel/penable/pready   | six registers at byte address 4*i
//
// an item runs capture, evaluate and finish when no mapping is needed, and when it is mapped:
// capture, evaluate, multiply, 11 steps of the restoring divider, finish.
// reset is synchronous and active low; thresholds come back to their register values.
// a result waits in the output register; a new item is taken meanwhile and its
// finish step holds until that register is free.
module servo_pulse_qualifier_mapper
    import spqm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // pulse_width[15:0]
    input  logic        i_s_tuser,   // cmd
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // throttle[10:0], trusted[11], signal_seen[12], clear_zero_count[13],
    // calibrating[14], high_done[15], calib_saved[16], high_code[26:17], low_code[36:27]
    output logic [39:0] o_m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg      cfg;
    t_ctl_cmd  cmd;
    t_ctl_stat stat;

    logic        r_bidir;
    logic [10:0] r_init_low;
    logic [11:0] r_init_high;
    logic [10:0] r_neutral;
    logic [10:0] r_max_step;
    logic [10:0] r_max_jit;

    wire       wr  = psel && penable && pwrite;
    wire [2:0] idx = paddr[4:2];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bidir     <= 1'b0;
            r_init_low  <= RST_INIT_LOW;
            r_init_high <= RST_INIT_HIGH;
            r_neutral   <= RST_NEUTRAL;
            r_max_step  <= RST_MAX_STEP;
            r_max_jit   <= RST_MAX_JIT;
        end else if (wr) begin
            case (idx)
                REG_BIDIR:     r_bidir     <= pwdata[0];
                REG_INIT_LOW:  r_init_low  <= pwdata[10:0];
                REG_INIT_HIGH: r_init_high <= pwdata[11:0];
                REG_NEUTRAL:   r_neutral   <= pwdata[10:0];
                REG_MAX_STEP:  r_max_step  <= pwdata[10:0];
                REG_MAX_JIT:   r_max_jit   <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        case (idx)
            REG_BIDIR:     prdata = {31'd0, r_bidir};
            REG_INIT_LOW:  prdata = {21'd0, r_init_low};
            REG_INIT_HIGH: prdata = {20'd0, r_init_high};
            REG_NEUTRAL:   prdata = {21'd0, r_neutral};
            REG_MAX_STEP:  prdata = {21'd0, r_max_step};
            REG_MAX_JIT:   prdata = {21'd0, r_max_jit};
            default:       prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    always_comb begin
        cfg.bidir      = r_bidir;
        cfg.init_low   = pwdata[10:0];
        cfg.init_high  = pwdata[11:0];
        cfg.neutral    = r_neutral;
        cfg.max_step   = r_max_step;
        cfg.max_jitter = r_max_jit;
        cfg.ld_low     = wr && (idx == REG_INIT_LOW);
        cfg.ld_high    = wr && (idx == REG_INIT_HIGH);
    end

    spqm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    spqm_dpath u_dpath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_cmd     (cmd),
        .o_stat    (stat),
        .i_cmd_bit (i_s_tuser),
        .i_pulse   (i_s_tdata),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_data    (o_m_tdata)
    );

endmodule

// ----- dv/tb_servo_pulse_qualifier_mapper.sv -----
`timescale 1ns / 1ps

module tb_servo_pulse_qualifier_mapper;
    import spqm_pkg::*;

    // result fields, highest first so the struct matches o_m_tdata[36:0]
    typedef struct packed {
        logic [9:0]  low_code;
        logic [9:0]  high_code;
        logic        calib_saved;
        logic        high_done;
        logic        calibrating;
        logic        clear_zero_count;
        logic        signal_seen;
        logic        trusted;
        logic [10:0] throttle;
    } t_servo_res;

    typedef struct {
        logic        cmd;
        logic [15:0] pw;
        logic        typed;
        t_servo_res  res;
    } t_row;

    localparam int unsigned LIMIT_CYCLES = 2000000;
    localparam int unsigned N_DIR = 22;

    // out of range pulse straight after reset
    localparam t_servo_res OOR_AFTER_RST = '{10'd125, 10'd125, 1'b0, 1'b0, 1'b0,
                                             1'b1, 1'b0, 1'b0, 11'd0};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [15:0] s_pw = '0;
    logic        s_cmd = 1'b0;
    logic        s_typed = 1'b0;
    t_servo_res  s_res = '0;
    logic        m_ready = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [39:0] o_m_tdata;
    logic [31:0] prdata;
    logic        pready;

    // predictor copy of registers and state
    logic        cf_bidir;
    logic [10:0] cf_init_low;
    logic [11:0] cf_init_high;
    logic [10:0] cf_neutral;
    logic [10:0] cf_step;
    logic [10:0] cf_jit;
    logic [11:0] sv_prev;
    logic [3:0]  sv_steady;
    logic [10:0] sv_raw;
    logic [10:0] sv_out;
    logic        sv_cal;
    logic        sv_hset;
    logic [7:0]  sv_hsamp;
    logic [6:0]  sv_lsamp;
    logic [11:0] sv_href;
    logic [11:0] sv_hthr;
    logic [11:0] sv_lthr;

    t_servo_res  pending_q[$];
    t_row        dir_rows[N_DIR];
    int unsigned err_cnt = 0;
    int unsigned cyc = 0;
    bit          no_gaps = 1'b0;
    int          cur_pw = 1500;

    servo_pulse_qualifier_mapper u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_pw),
        .i_s_tuser  (s_cmd),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_ready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #1 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > LIMIT_CYCLES) begin
            $display("tb_servo_pulse_qualifier_mapper: FAIL");
            $finish;
        end
    end

    function automatic int unsigned map_clamped(int unsigned x, int unsigned lo,
                                                int unsigned hi, int unsigned olo,
                                                int unsigned ohi);
        if (hi <= lo) return olo;
        if (x < lo) x = lo;
        if (x > hi) x = hi;
        return (x - lo) * (ohi - olo) / (hi - lo) + olo;
    endfunction

    function automatic logic [9:0] thr_code(logic [11:0] thr, int base);
        int c;
        c = (int'(thr) - base) / 2;
        if (c > 511) c = 511;
        if (c < -512) c = -512;
        return c[9:0];
    endfunction

    // advance the servo state by one item and return its result
    function automatic t_servo_res servo_next(logic cmd, logic [15:0] p);
        t_servo_res  r;
        bit          slew;
        bit          go;
        int unsigned jit;
        int unsigned d;
        int unsigned raw;
        int          cur;
        r = '0;
        slew = 1'b1;
        if (cmd) begin
            if (!sv_hset) sv_cal = 1'b1;
            slew = 1'b0;
        end else begin
            go = (p > 16'd800) && (p < 16'd2200);
            if (go) begin
                jit = (p > sv_prev) ? p - sv_prev : sv_prev - p;
                sv_prev = p[11:0];
                if (jit > cf_jit) sv_steady = 0;
                else if (sv_steady < FRAMES_TO_TRUST) sv_steady++;
                if (sv_steady < FRAMES_TO_TRUST) begin
                    r.clear_zero_count = 1'b1;
                    go = 1'b0;
                    slew = 1'b0;
                end
            end else begin
                sv_steady = 0;
                r.clear_zero_count = 1'b1;
            end
            if (go) begin
                r.signal_seen = 1'b1;
                raw = sv_raw;
                if (sv_cal) begin
                    if (!sv_hset) begin
                        if (sv_hsamp == 0) sv_href = p[11:0];
                        sv_hsamp++;
                        d = (sv_href > sv_hthr) ? sv_href - sv_hthr : sv_hthr - sv_href;
                        if (d > 50) begin
                            sv_cal = 1'b0;
                        end else begin
                            sv_hthr = 12'((7 * int'(sv_hthr) + int'(p)) >> 3);
                            if (sv_hsamp > 50) begin
                                sv_hthr = sv_hthr - 12'd25;
                                sv_hset = 1'b1;
                            end
                        end
                        sv_href = sv_hthr;
                    end
                    if (sv_hset) begin
                        if (p < 16'd1250) begin
                            sv_lsamp++;
                            sv_lthr = 12'((7 * int'(sv_lthr) + int'(p)) >> 3);
                        end
                        if (sv_lsamp > 75) begin
                            sv_lthr = sv_lthr + 12'd25;
                            sv_cal = 1'b0;
                            sv_lsamp = 0;
                            r.calib_saved = 1'b1;
                        end
                    end
                end else if (cf_bidir) begin
                    if (p <= cf_neutral)
                        raw = map_clamped(p, sv_lthr, cf_neutral, 0, 1000);
                    else
                        raw = map_clamped(p, cf_neutral + 1, sv_hthr, 1001, 2000);
                end else begin
                    raw = map_clamped(p, sv_lthr, sv_hthr, 47, 2047);
                    if (raw <= 48) raw = 0;
                end
                sv_raw = raw[10:0];
            end
        end
        // slew toward the raw throttle
        if (slew) begin
            cur = sv_out;
            if (int'(sv_raw) - cur > int'(cf_step)) cur += cf_step;
            else if (cur - int'(sv_raw) > int'(cf_step)) cur -= cf_step;
            else cur = sv_raw;
            sv_out = cur[10:0];
        end
        r.throttle = sv_out;
        r.trusted = (sv_steady >= FRAMES_TO_TRUST);
        r.calibrating = sv_cal;
        r.high_done = sv_hset;
        r.high_code = thr_code(sv_hthr, 1750);
        r.low_code = thr_code(sv_lthr, 750);
        return r;
    endfunction

    task automatic field_chk(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            err_cnt++;
        end
    endtask

    // predict on each accepted input item, compare each accepted result
    always @(posedge i_clk) begin
        t_servo_res want;
        t_servo_res got;
        if (i_rst_n) begin
            if (s_valid && o_s_tready) begin
                want = servo_next(s_cmd, s_pw);
                if (s_typed) want = s_res;
                pending_q.push_back(want);
            end
            if (o_m_tvalid && m_ready) begin
                got = o_m_tdata[36:0];
                if (pending_q.size() == 0) begin
                    $error("result item with nothing expected");
                    err_cnt++;
                end else begin
                    want = pending_q.pop_front();
                    field_chk("throttle", want.throttle, got.throttle);
                    field_chk("trusted", want.trusted, got.trusted);
                    field_chk("signal_seen", want.signal_seen, got.signal_seen);
                    field_chk("clear_zero_count", want.clear_zero_count,
                              got.clear_zero_count);
                    field_chk("calibrating", want.calibrating, got.calibrating);
                    field_chk("high_done", want.high_done, got.high_done);
                    field_chk("calib_saved", want.calib_saved, got.calib_saved);
                    field_chk("high_code", want.high_code, got.high_code);
                    field_chk("low_code", want.low_code, got.low_code);
                end
            end
        end
    end

    // receiver: stretches of ready and stalls, mostly short
    always @(posedge i_clk) begin
        int unsigned left;
        int unsigned r;
        if (left == 0) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                m_ready <= 1'b1;
                left = $urandom_range(1, 60);
            end else begin
                m_ready <= 1'b0;
                left = (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
            end
        end else begin
            left--;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(logic cmd, logic [15:0] pw, logic typed, t_servo_res res);
        int unsigned gap;
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_pw <= pw;
        s_typed <= typed;
        s_res <= res;
        do @(posedge i_clk); while (!o_s_tready);
        gap = pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_pulse(int pw);
        send_item(1'b0, pw[15:0], 1'b0, '0);
    endtask

    task automatic drain();
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_BIDIR:     cf_bidir = val[0];
            REG_INIT_LOW:  begin cf_init_low = val[10:0]; sv_lthr = {1'b0, val[10:0]}; end
            REG_INIT_HIGH: begin cf_init_high = val[11:0]; sv_hthr = val[11:0]; end
            REG_NEUTRAL:   cf_neutral = val[10:0];
            REG_MAX_STEP:  cf_step = val[10:0];
            REG_MAX_JIT:   cf_jit = val[10:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(int bidir, int lo, int hi, int neu, int step, int jit);
        s_valid <= 1'b0;
        drain();
        reg_write(REG_BIDIR, bidir);
        reg_write(REG_INIT_LOW, lo);
        reg_write(REG_INIT_HIGH, hi);
        reg_write(REG_NEUTRAL, neu);
        reg_write(REG_MAX_STEP, step);
        reg_write(REG_MAX_JIT, jit);
    endtask

    task automatic set_random_regs();
        set_regs($urandom_range(0, 1), $urandom_range(750, 1274), $urandom_range(1750, 2254),
                 $urandom_range(1000, 2000), $urandom_range(0, 2047),
                 $urandom_range(0, 2047));
    endtask

    // pulse that wanders within the jitter limit, kept in range
    task automatic steady_run(int n);
        int js;
        js = (cf_jit > 100) ? 100 : cf_jit;
        repeat (n) begin
            cur_pw += $urandom_range(0, 2 * js) - js;
            if (cur_pw < 801) cur_pw = 801;
            if (cur_pw > 2199) cur_pw = 2199;
            send_pulse(cur_pw);
        end
    endtask

    task automatic random_part(int n);
        int k;
        int unsigned r;
        k = 0;
        while (k < n) begin
            r = $urandom_range(0, 99);
            if (r < 20) begin
                send_item($urandom_range(0, 9) == 0, $urandom_range(0, 65535), 1'b0, '0);
                k++;
            end else if (r < 27) begin
                // in range but far jump
                cur_pw = $urandom_range(801, 2199);
                send_pulse(cur_pw);
                k++;
            end else begin
                if ($urandom_range(0, 3) == 0) cur_pw = $urandom_range(801, 2199);
                r = $urandom_range(10, 40);
                steady_run(r);
                k += r;
            end
        end
    endtask

    // ramp in steps of at most 150, then hold near a target
    task automatic hold_near(int target, int n);
        while (cur_pw != target) begin
            if (cur_pw < target) cur_pw = (target - cur_pw > 150) ? cur_pw + 150 : target;
            else cur_pw = (cur_pw - target > 150) ? cur_pw - 150 : target;
            send_pulse(cur_pw);
        end
        repeat (n) send_pulse(target + $urandom_range(0, 6) - 3);
    endtask

    task automatic full_calibration();
        hold_near(2000, 10);
        send_item(1'b1, $urandom_range(0, 65535), 1'b0, '0);
        hold_near(2000, 60);
        hold_near(1000, 90);
        // start command once the high side is done is ignored
        send_item(1'b1, 16'd1500, 1'b0, '0);
        hold_near(1500, 20);
    endtask

    initial begin
        int i;
        cf_bidir = 1'b0;
        cf_init_low = RST_INIT_LOW;
        cf_init_high = RST_INIT_HIGH;
        cf_neutral = RST_NEUTRAL;
        cf_step = RST_MAX_STEP;
        cf_jit = RST_MAX_JIT;
        sv_prev = '0;
        sv_steady = '0;
        sv_raw = '0;
        sv_out = '0;
        sv_cal = 1'b0;
        sv_hset = 1'b0;
        sv_hsamp = '0;
        sv_lsamp = '0;
        sv_href = '0;
        sv_hthr = RST_INIT_HIGH;
        sv_lthr = {1'b0, RST_INIT_LOW};

        // directed table: range edges, trust build-up, jitter reset, start command
        dir_rows[0] = '{1'b0, 16'd0, 1'b1, OOR_AFTER_RST};
        dir_rows[1] = '{1'b0, 16'hFFFF, 1'b1, OOR_AFTER_RST};
        dir_rows[2] = '{1'b0, 16'd800, 1'b1, OOR_AFTER_RST};
        dir_rows[3] = '{1'b0, 16'd2200, 1'b1, OOR_AFTER_RST};
        for (i = 4; i < 13; i++) dir_rows[i] = '{1'b0, 16'd801, 1'b0, '0};
        dir_rows[13] = '{1'b0, 16'd2199, 1'b0, '0};
        for (i = 14; i < 20; i++) dir_rows[i] = '{1'b0, 16'(1900 + i), 1'b0, '0};
        dir_rows[20] = '{1'b1, 16'hFFFF, 1'b0, '0};
        dir_rows[21] = '{1'b0, 16'd2500, 1'b0, '0};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < N_DIR; i++)
            send_item(dir_rows[i].cmd, dir_rows[i].pw, dir_rows[i].typed, dir_rows[i].res);
        random_part(150);

        // full calibration under defaults, no sender gaps for a stretch
        set_regs(0, 1000, 2000, 1500, 250, 400);
        full_calibration();
        no_gaps = 1'b1;
        random_part(150);
        no_gaps = 1'b0;

        // widest limits, bidirectional
        set_regs(1, 750, 2254, 1000, 2047, 2047);
        random_part(250);
        // tightest limits, degenerate neutral below low threshold
        set_regs(1, 1274, 1750, 1000, 0, 0);
        hold_near(1200, 12);
        random_part(150);
        set_regs(0, 1274, 1750, 2000, 0, 0);
        random_part(150);
        set_regs(1, 750, 1750, 2000, 1, 1);
        random_part(150);
        repeat (5) begin
            set_random_regs();
            random_part(120);
        end

        s_valid <= 1'b0;
        drain();
        repeat (20) @(posedge i_clk);
        if (err_cnt == 0 && pending_q.size() == 0) begin
            $display("tb_servo_pulse_qualifier_mapper: PASS");
        end else begin
            $display("tb_servo_pulse_qualifier_mapper: FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/spqm_pkg.sv
src/spqm_ctrl.sv
src/spqm_dpath.sv
src/servo_pulse_qualifier_mapper.sv
dv/tb_servo_pulse_qualifier_mapper.sv
